>>> rtl/ltsc_pkg.sv
`timescale 1ns / 1ps
// shared types and codes for the tile slot cache
// no dependencies

package ltsc_pkg;

  localparam int COORD_W   = 22;
  localparam int KEY_W     = 20;
  localparam int ZOOM_W    = 5;
  localparam int STAMP_W   = 32;
  localparam int SLOT_W    = 6;
  localparam int STATUS_W  = 3;
  localparam int IN_DATA_W = 96;
  localparam int OUT_DATA_W = 16;

  localparam logic [ZOOM_W-1:0] ZOOM_LIMIT = 5'd20;

  // commands
  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_MARK   = 2'd1;
  localparam logic [1:0] CMD_FLUSH  = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_REJECT     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_HIT_LOADED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_HIT_EMPTY  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NEW        = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EVICT      = 3'd4;
  localparam logic [STATUS_W-1:0] ST_MARKED     = 3'd5;
  localparam logic [STATUS_W-1:0] ST_FLUSHED    = 3'd6;

  // tile key plus the stamp written with it
  typedef struct packed {
    logic [KEY_W-1:0]   col;
    logic [KEY_W-1:0]   row;
    logic [ZOOM_W-1:0]  zoom;
    logic [STAMP_W-1:0] stamp;
  } key_t;

  // per-slot update commands, qualified by a slot index (flush applies to every slot)
  typedef struct packed {
    logic fill;   // write key and stamp, clear loaded
    logic touch;  // refresh stamp only
    logic mark;   // set loaded
    logic flush;  // clear loaded in every slot
  } cell_ctl_t;

  // search token passed down the row of cells
  typedef struct packed {
    logic               vld;
    logic               hit;
    logic               hit_loaded;
    logic               have_min;
    logic               min_loaded;
    logic [STAMP_W-1:0] min_stamp;
  } tok_t;

endpackage

>>> rtl/ltsc_cell.sv
`timescale 1ns / 1ps
// one directory slot: holds an entry and updates the passing search token
// depends on ltsc_pkg

module ltsc_cell import ltsc_pkg::*; #(
  parameter int CACHE_ENTRIES = 64,
  parameter int IDX = 0
) (
  input  logic clk,
  input  logic rst_n,
  input  logic [$clog2(CACHE_ENTRIES+1)-1:0] used_count,
  input  key_t key,
  input  cell_ctl_t ctl,
  input  logic [((CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1)-1:0] wr_idx,
  input  tok_t tok_i,
  input  logic [((CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1)-1:0] hit_idx_i,
  input  logic [((CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1)-1:0] min_idx_i,
  output tok_t tok_o,
  output logic [((CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1)-1:0] hit_idx_o,
  output logic [((CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1)-1:0] min_idx_o
);

  localparam int IW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int CW = $clog2(CACHE_ENTRIES+1);
  localparam logic [IW-1:0] MY_IDX = IW'(IDX);
  localparam logic [CW-1:0] MY_CNT = CW'(IDX);

  logic [KEY_W-1:0]   col_r, row_r;
  logic [ZOOM_W-1:0]  zoom_r;
  logic [STAMP_W-1:0] stamp_r;
  logic               loaded_r;

  tok_t            tok_nxt, tok_r;
  logic [IW-1:0]   hit_idx_nxt, hit_idx_r, min_idx_nxt, min_idx_r;

  logic in_use, match, better, sel;

  assign sel    = (wr_idx == MY_IDX);
  assign in_use = (MY_CNT < used_count);
  assign match  = in_use && (col_r == key.col) && (row_r == key.row) && (zoom_r == key.zoom);
  // strict less keeps the lowest index on ties
  assign better = in_use && (!tok_i.have_min || (stamp_r < tok_i.min_stamp));

  always_comb begin
    tok_nxt     = tok_i;
    hit_idx_nxt = hit_idx_i;
    min_idx_nxt = min_idx_i;
    if (match && !tok_i.hit) begin
      tok_nxt.hit        = 1'b1;
      tok_nxt.hit_loaded = loaded_r;
      hit_idx_nxt        = MY_IDX;
    end
    if (better) begin
      tok_nxt.have_min   = 1'b1;
      tok_nxt.min_stamp  = stamp_r;
      tok_nxt.min_loaded = loaded_r;
      min_idx_nxt        = MY_IDX;
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    if (sel && ctl.fill) begin
      col_r   <= key.col;
      row_r   <= key.row;
      zoom_r  <= key.zoom;
      stamp_r <= key.stamp;
    end else if (sel && ctl.touch) begin
      stamp_r <= key.stamp;
    end
    hit_idx_r        <= hit_idx_nxt;
    min_idx_r        <= min_idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r  <= 1'b0;
      tok_r     <= '0;
    end else begin
      tok_r <= tok_nxt;
      if (ctl.flush || (sel && ctl.fill)) begin
        loaded_r <= 1'b0;
      end else if (sel && ctl.mark) begin
        loaded_r <= 1'b1;
      end
    end
  end

  assign tok_o     = tok_r;
  assign hit_idx_o = hit_idx_r;
  assign min_idx_o = min_idx_r;

endmodule

>>> rtl/lru_tile_slot_cache_top.sv
`timescale 1ns / 1ps
// tile slot directory with timestamp lru replacement, top level
// depends on ltsc_pkg and ltsc_cell
//
// mark, flush and rejected words go from idle straight to the done state, which loads the
//   result register; a lookup that passes the range checks first launches the search token,
//   which walks one cell per cycle down the row of slots; the scan state applies the outcome
// throughput: one word at a time, next word accepted from the edge that registers the result;
//   a result word not yet taken holds the block in its done state
// reset: synchronous active-low rst_n clears enable, fill count, loaded flags and
//   the handshake state; entry keys and stamps are not cleared

module lru_tile_slot_cache_top import ltsc_pkg::*; #(
  parameter int CACHE_ENTRIES = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // command word: command[1:0], tile_x[23:2], tile_y[45:24], zoom[50:46],
  // now[82:51], slot_index[88:83], zero fill above
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // result word: status[2:0], slot[8:3], evicted_was_loaded[9], zero fill above
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  // enable register write
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_data
);

  localparam int IW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int CW = $clog2(CACHE_ENTRIES+1);
  localparam logic [CW-1:0] FULL_CNT = CW'(CACHE_ENTRIES);

  // controller states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  // unpack the command word
  logic [1:0]          command;
  logic [COORD_W-1:0]  tile_x, tile_y;
  logic [ZOOM_W-1:0]   zoom;
  logic [STAMP_W-1:0]  now;
  logic [SLOT_W-1:0]   slot_index;

  assign command    = in_tdata[1:0];
  assign tile_x     = in_tdata[23:2];
  assign tile_y     = in_tdata[45:24];
  assign zoom       = in_tdata[50:46];
  assign now        = in_tdata[82:51];
  assign slot_index = in_tdata[88:83];

  logic [1:0]          state_r, state_nxt;
  logic                enable_r;
  logic [CW-1:0]       used_r, used_nxt;
  key_t                key_r, key_nxt;
  logic                launch_r, launch_nxt;

  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [SLOT_W-1:0]   res_slot_r, res_slot_nxt;
  logic                res_ev_r, res_ev_nxt;

  logic                out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  cell_ctl_t           ctl;
  logic [IW-1:0]       wr_idx;

  // token chain: stage 0 is the launch point, stage N leaves the last cell
  tok_t                tok     [CACHE_ENTRIES+1];
  logic [IW-1:0]       hit_idx [CACHE_ENTRIES+1];
  logic [IW-1:0]       min_idx [CACHE_ENTRIES+1];

  logic in_fire, out_free, coord_bad, lookup_ok, mark_ok;
  logic [COORD_W-1:0] x_hi, y_hi;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // coordinates must be non-negative and below 2^zoom (zoom is checked against the cap of 20 separately)
  assign x_hi      = tile_x >> zoom;
  assign y_hi      = tile_y >> zoom;
  assign coord_bad = tile_x[COORD_W-1] || tile_y[COORD_W-1] || (x_hi != '0) || (y_hi != '0);
  assign lookup_ok = enable_r && (zoom <= ZOOM_LIMIT) && !coord_bad;
  // a slot can only be marked while it is in use; mark ignores enable
  assign mark_ok   = (11'(slot_index) < 11'(used_r));

  assign tok[0]     = '{vld: launch_r, hit: 1'b0, hit_loaded: 1'b0, have_min: 1'b0,
                        min_loaded: 1'b0, min_stamp: '0};
  assign hit_idx[0] = '0;
  assign min_idx[0] = '0;

  always_comb begin
    state_nxt      = state_r;
    used_nxt       = used_r;
    key_nxt        = key_r;
    launch_nxt     = 1'b0;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_ev_nxt     = res_ev_r;
    ctl            = '0;
    wr_idx         = '0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_status_nxt = ST_REJECT;
          res_slot_nxt   = '0;
          res_ev_nxt     = 1'b0;
          state_nxt      = S_DONE;
          case (command)
            CMD_LOOKUP: begin
              if (lookup_ok) begin
                key_nxt.col   = tile_x[KEY_W-1:0];
                key_nxt.row   = tile_y[KEY_W-1:0];
                key_nxt.zoom  = zoom;
                key_nxt.stamp = now;
                launch_nxt    = 1'b1;
                state_nxt     = S_SCAN;
              end
            end
            CMD_MARK: begin
              if (mark_ok) begin
                ctl.mark       = 1'b1;
                wr_idx         = IW'(slot_index);
                res_status_nxt = ST_MARKED;
                res_slot_nxt   = slot_index;
              end
            end
            CMD_FLUSH: begin
              ctl.flush      = 1'b1;
              used_nxt       = '0;
              res_status_nxt = ST_FLUSHED;
            end
            default: begin
              res_status_nxt = ST_REJECT;
            end
          endcase
        end
      end
      S_SCAN: begin
        // token has passed every slot: apply the outcome
        if (tok[CACHE_ENTRIES].vld) begin
          state_nxt = S_DONE;
          res_ev_nxt = 1'b0;
          if (tok[CACHE_ENTRIES].hit) begin
            ctl.touch      = 1'b1;
            wr_idx         = hit_idx[CACHE_ENTRIES];
            res_slot_nxt   = SLOT_W'(hit_idx[CACHE_ENTRIES]);
            res_status_nxt = tok[CACHE_ENTRIES].hit_loaded ? ST_HIT_LOADED : ST_HIT_EMPTY;
          end else if (used_r < FULL_CNT) begin
            ctl.fill       = 1'b1;
            wr_idx         = IW'(used_r);
            used_nxt       = used_r + CW'(1);
            res_slot_nxt   = SLOT_W'(used_r);
            res_status_nxt = ST_NEW;
          end else begin
            ctl.fill       = 1'b1;
            wr_idx         = min_idx[CACHE_ENTRIES];
            res_slot_nxt   = SLOT_W'(min_idx[CACHE_ENTRIES]);
            res_status_nxt = ST_EVICT;
            res_ev_nxt     = tok[CACHE_ENTRIES].min_loaded;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      enable_r    <= 1'b0;
      used_r      <= '0;
      launch_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      used_r   <= used_nxt;
      launch_r <= launch_nxt;
      if (cfg_valid && cfg_ready) begin
        enable_r <= cfg_data;
      end
      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_ev_r     <= res_ev_nxt;
    if ((state_r == S_DONE) && out_free) begin
      out_data_r <= {6'b0, res_ev_r, res_slot_r, res_status_r};
    end
  end

  // row of slot cells, the token moves one cell per cycle
  for (genvar i = 0; i < CACHE_ENTRIES; i++) begin : g_cell
    ltsc_cell #(
      .CACHE_ENTRIES (CACHE_ENTRIES),
      .IDX           (i)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .used_count (used_r),
      .key        (key_r),
      .ctl        (ctl),
      .wr_idx     (wr_idx),
      .tok_i      (tok[i]),
      .hit_idx_i  (hit_idx[i]),
      .min_idx_i  (min_idx[i]),
      .tok_o      (tok[i+1]),
      .hit_idx_o  (hit_idx[i+1]),
      .min_idx_o  (min_idx[i+1])
    );
  end

endmodule
